>>> rtl/pfc_pkg.sv
`default_nettype none
package pfc_pkg;

  typedef logic [4:0] letter_t;

  // Key square, indexed [row][column]
  typedef logic [4:0][4:0][4:0] square_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_CELLS_LOW  = 2'd1,
    REG_CELLS_HIGH = 2'd2,
    REG_CELL_LAST  = 2'd3
  } reg_index_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_Z = 5'd25;

  localparam logic [59:0] CELLS_LOW_RESET  = 60'd635082568189906123;
  localparam logic [59:0] CELLS_HIGH_RESET = 60'd710189213288207629;
  localparam letter_t     CELL_LAST_RESET  = 5'd15;

endpackage
`default_nettype wire

>>> rtl/pfc_pair_cipher.sv
`default_nettype none
module pfc_pair_cipher (
  input  pfc_pkg::square_t square,
  input  logic             decrypt,
  input  pfc_pkg::letter_t first,
  input  pfc_pkg::letter_t second,
  output pfc_pkg::letter_t first_out,
  output pfc_pkg::letter_t second_out
);
  import pfc_pkg::*;

  // First cell in row-major order wins; an absent letter sits at the top left
  function automatic pos_t locate(square_t sq, letter_t l);
    pos_t p;
    p = '0;
    for (int r = 4; r >= 0; r--) begin
      for (int c = 4; c >= 0; c--) begin
        if (sq[r][c] == l) begin
          p.row = 3'(r);
          p.col = 3'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [2:0] wrap_step(logic [2:0] v, logic dec);
    logic [2:0] n;
    if (dec) begin
      n = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      n = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return n;
  endfunction

  pos_t pa, pb;

  always_comb begin
    pa = locate(square, first);
    pb = locate(square, second);
    if (pa.row == pb.row) begin
      first_out  = square[pa.row][wrap_step(pa.col, decrypt)];
      second_out = square[pb.row][wrap_step(pb.col, decrypt)];
    end else if (pa.col == pb.col) begin
      first_out  = square[wrap_step(pa.row, decrypt)][pa.col];
      second_out = square[wrap_step(pb.row, decrypt)][pb.col];
    end else begin
      first_out  = square[pa.row][pb.col];
      second_out = square[pb.row][pa.col];
    end
  end

endmodule
`default_nettype wire

>>> rtl/playfair_digraph_cipher_top.sv
`default_nettype none
// Playfair digraph cipher over a stream of letter codes.
// Input channel: in_valid/in_stall carry letter_in and message_end, one letter
// per request. Output channel: out_valid/out_stall carry letter_out, run_last
// (last letter caused by a request) and message_done (last letter of message).
// The user must write the key square and mode over the APB port only while the
// block is idle; the block itself does not enforce it. An accepted request
// updates the pairing state at once and, when it closes one or two digraphs,
// becomes a job of two or four letters. The job is enciphered one digraph at a
// time by combinational logic and shifted out one letter a cycle while the
// receiver does not stall. The first letter passes through the job register
// and then the output register. A request that yields letters holds the input
// until its job's final letter moves to the output register; the next request
// is taken in that cycle, so back-to-back requests see no bubble. A request that
// yields none does not stall the input. When the receiver stalls, the output
// register holds, the job holds and in_stall stays high.
// Reset empties the job and output registers, clears the pairing state and
// loads the default square with mode set to encrypt.
module playfair_digraph_cipher_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire pfc_pkg::letter_t letter_in,
  input  wire logic             message_end,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      pfc_pkg::letter_t letter_out,
  output      logic             run_last,
  output      logic             message_done,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output      logic [63:0]      prdata,
  output      logic             pready
);
  import pfc_pkg::*;

  // Configuration registers
  logic        cipher_mode;
  logic [59:0] cells_low;
  logic [59:0] cells_high;
  letter_t     cell_last;
  reg_index_t  reg_sel;
  logic        cfg_write;
  square_t     square;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= 1'b0;
      cells_low   <= CELLS_LOW_RESET;
      cells_high  <= CELLS_HIGH_RESET;
      cell_last   <= CELL_LAST_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MODE:       cipher_mode <= pwdata[0];
        REG_CELLS_LOW:  cells_low   <= pwdata[59:0];
        REG_CELLS_HIGH: cells_high  <= pwdata[59:0];
        REG_CELL_LAST:  cell_last   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:       prdata = {63'd0, cipher_mode};
      REG_CELLS_LOW:  prdata = {4'd0, cells_low};
      REG_CELLS_HIGH: prdata = {4'd0, cells_high};
      REG_CELL_LAST:  prdata = {59'd0, cell_last};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (r * 5 + c < 12) begin
          square[r][c] = cells_low[5 * (r * 5 + c) +: 5];
        end else if (r * 5 + c < 24) begin
          square[r][c] = cells_high[5 * (r * 5 + c - 12) +: 5];
        end else begin
          square[r][c] = cell_last;
        end
      end
    end
  end

  // Pairing state
  letter_t pending_letter, pending_letter_next;
  logic    pending_valid, pending_valid_next;
  letter_t previous_letter;
  logic    previous_valid;

  // Job: up to two raw digraphs waiting to be enciphered
  logic       job_valid;
  letter_t    job_a0, job_b0, job_a1, job_b1;
  logic       job_two;
  logic       job_end;
  logic [1:0] job_idx;

  // Output register
  logic out_load;
  logic job_final;
  logic job_done;
  logic in_accept;

  assign out_load  = !out_valid || !out_stall;
  assign job_final = (job_idx == {job_two, 1'b1});
  assign job_done  = job_valid && out_load && job_final;
  assign in_stall  = job_valid && !job_done;
  assign in_accept = in_valid && !in_stall;

  // Accept-side pairing logic
  letter_t letter_fold;
  logic    dup;
  logic    pair_a, pair_end;
  letter_t pa_first, pa_second;
  letter_t n_a0, n_b0, n_a1, n_b1;
  logic    n_any, n_two;

  always_comb begin
    letter_fold = (letter_in > LETTER_Z) ? LETTER_Z : letter_in;
    if (letter_fold == LETTER_J) begin
      letter_fold = LETTER_I;
    end
    dup = !cipher_mode && previous_valid && (previous_letter == letter_fold);

    pending_letter_next = pending_letter;
    pending_valid_next  = pending_valid;
    pair_a    = 1'b0;
    pa_first  = pending_letter;
    pa_second = LETTER_X;
    if (dup) begin
      pair_a = 1'b1;
      if (pending_valid) begin
        pending_letter_next = letter_fold;
      end else begin
        pa_first  = LETTER_X;
        pa_second = letter_fold;
      end
    end else if (pending_valid) begin
      pair_a             = 1'b1;
      pa_second          = letter_fold;
      pending_valid_next = 1'b0;
    end else begin
      pending_letter_next = letter_fold;
      pending_valid_next  = 1'b1;
    end

    // Pad a lone letter at the end of the message
    pair_end = message_end && pending_valid_next;

    if (pair_a) begin
      n_a0 = pa_first;
      n_b0 = pa_second;
    end else begin
      n_a0 = pending_letter_next;
      n_b0 = LETTER_X;
    end
    n_a1  = pending_letter_next;
    n_b1  = LETTER_X;
    n_any = pair_a || pair_end;
    n_two = pair_a && pair_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_letter  <= '0;
      pending_valid   <= 1'b0;
      previous_letter <= '0;
      previous_valid  <= 1'b0;
    end else if (in_accept) begin
      if (message_end) begin
        pending_letter  <= '0;
        pending_valid   <= 1'b0;
        previous_letter <= '0;
        previous_valid  <= 1'b0;
      end else begin
        pending_letter  <= pending_letter_next;
        pending_valid   <= pending_valid_next;
        previous_letter <= letter_fold;
        previous_valid  <= 1'b1;
      end
    end
  end

  // Encipher the current digraph of the job
  letter_t cur_first, cur_second;
  letter_t ciph_first, ciph_second;

  assign cur_first  = job_idx[1] ? job_a1 : job_a0;
  assign cur_second = job_idx[1] ? job_b1 : job_b0;

  pfc_pair_cipher u_pair_cipher (
    .square     (square),
    .decrypt    (cipher_mode),
    .first      (cur_first),
    .second     (cur_second),
    .first_out  (ciph_first),
    .second_out (ciph_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= '0;
    end else if (in_accept) begin
      job_valid <= n_any;
      job_idx   <= '0;
    end else if (job_done) begin
      job_valid <= 1'b0;
      job_idx   <= '0;
    end else if (job_valid && out_load) begin
      job_idx <= job_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_a0  <= n_a0;
      job_b0  <= n_b0;
      job_a1  <= n_a1;
      job_b1  <= n_b1;
      job_two <= n_two;
      job_end <= message_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && job_valid) begin
      letter_out   <= job_idx[0] ? ciph_second : ciph_first;
      run_last     <= job_final;
      message_done <= job_final && job_end;
    end
  end

  a_done_is_run_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> run_last)
    else $error("message_done without run_last");

  a_end_clears_state : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && message_end |=> !pending_valid && !previous_valid)
    else $error("pairing state not cleared at end of message");

  a_job_index_range : assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_two || !job_idx[1]))
    else $error("job index beyond its digraphs");

  a_job_holds_on_stall : assert property (@(posedge clk) disable iff (rst)
    job_valid && out_valid && out_stall |=> job_valid && $stable(job_idx))
    else $error("job advanced while output stalled");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
  import pfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [59:0] ALL_CELLS_SET = 60'hFFF_FFFF_FFFF_FFFF;

  typedef struct {
    letter_t letter;
    logic    last;
  } letter_request_t;

  typedef struct {
    letter_t letter;
    logic    run_last;
    logic    message_done;
  } cipher_letter_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  letter_t     letter_in = '0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  letter_t     letter_out;
  logic        run_last;
  logic        message_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  playfair_digraph_cipher_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .letter_in(letter_in), .message_end(message_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .letter_out(letter_out), .run_last(run_last), .message_done(message_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's registers and pairing state
  logic        shadow_decrypt = 1'b0;
  logic [59:0] shadow_cells_low = CELLS_LOW_RESET;
  logic [59:0] shadow_cells_high = CELLS_HIGH_RESET;
  letter_t     shadow_cell_last = CELL_LAST_RESET;
  letter_t     held_letter = '0;
  logic        held_valid = 1'b0;
  letter_t     last_seen_letter = '0;
  logic        last_seen_valid = 1'b0;

  letter_request_t letter_requests[$];
  cipher_letter_t  expected_letters[$];
  int unsigned     pushed_count = 0;
  int unsigned     accepted_count = 0;
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;

  function automatic letter_t square_cell(int idx);
    if (idx < 12) return shadow_cells_low[5*idx +: 5];
    if (idx < 24) return shadow_cells_high[5*(idx-12) +: 5];
    return shadow_cell_last;
  endfunction

  // First matching cell in row major order; absent letters sit at the corner
  task automatic find_cell(input letter_t ltr, output int row, output int col);
    row = 0;
    col = 0;
    for (int i = 24; i >= 0; i--) begin
      if (square_cell(i) == ltr) begin
        row = i / 5;
        col = i % 5;
      end
    end
  endtask

  task automatic cipher_digraph(input letter_t a, input letter_t b,
                                inout cipher_letter_t step_letters[$]);
    int ra, ca, rb, cb, shift;
    cipher_letter_t res_a, res_b;
    shift = shadow_decrypt ? 4 : 1;
    find_cell(a, ra, ca);
    find_cell(b, rb, cb);
    res_a = '{letter: '0, run_last: 1'b0, message_done: 1'b0};
    res_b = res_a;
    if (ra == rb) begin
      res_a.letter = square_cell(ra*5 + (ca + shift) % 5);
      res_b.letter = square_cell(rb*5 + (cb + shift) % 5);
    end else if (ca == cb) begin
      res_a.letter = square_cell(((ra + shift) % 5)*5 + ca);
      res_b.letter = square_cell(((rb + shift) % 5)*5 + cb);
    end else begin
      res_a.letter = square_cell(ra*5 + cb);
      res_b.letter = square_cell(rb*5 + ca);
    end
    step_letters.push_back(res_a);
    step_letters.push_back(res_b);
  endtask

  task automatic encipher_request(input letter_t raw, input logic last);
    letter_t ltr;
    cipher_letter_t step_letters[$];
    cipher_letter_t tail;
    ltr = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (ltr == LETTER_J) ltr = LETTER_I;
    if (!shadow_decrypt && last_seen_valid && last_seen_letter == ltr) begin
      // doubled letter: split it with a filler
      if (held_valid) begin
        cipher_digraph(held_letter, LETTER_X, step_letters);
        held_letter = ltr;
      end else begin
        cipher_digraph(LETTER_X, ltr, step_letters);
      end
    end else if (held_valid) begin
      cipher_digraph(held_letter, ltr, step_letters);
      held_valid = 1'b0;
    end else begin
      held_letter = ltr;
      held_valid = 1'b1;
    end
    last_seen_letter = ltr;
    last_seen_valid = 1'b1;
    if (last) begin
      if (held_valid) cipher_digraph(held_letter, LETTER_X, step_letters);
      held_valid = 1'b0;
      held_letter = '0;
      last_seen_valid = 1'b0;
      last_seen_letter = '0;
    end
    if (step_letters.size() > 0) begin
      tail = step_letters.pop_back();
      tail.run_last = 1'b1;
      tail.message_done = last;
      step_letters.push_back(tail);
    end
    foreach (step_letters[i]) expected_letters.push_back(step_letters[i]);
  endtask

  // Request driver: bursts of random length, random gaps between them
  letter_request_t next_request;
  int unsigned     burst_left = 4;
  int unsigned     gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encipher_request(letter_in, message_end);
        accepted_count++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (letter_requests.size() > 0) begin
          next_request = letter_requests.pop_front();
          in_valid <= 1'b1;
          letter_in <= next_request.letter;
          message_end <= next_request.last;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with its own stall pattern
  int unsigned stall_kind = 0;
  int unsigned stall_span = 0;
  cipher_letter_t seen_expect;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_span = $urandom_range(10, 60);
    end
    stall_span--;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
    if (!rst && out_valid && !out_stall) begin
      if (expected_letters.size() == 0) begin
        $error("unexpected letter %0d with nothing outstanding", letter_out);
        error_count++;
      end else begin
        seen_expect = expected_letters.pop_front();
        if (letter_out !== seen_expect.letter) begin
          $error("letter_out: expected %0d, got %0d", seen_expect.letter, letter_out);
          error_count++;
        end
        if (run_last !== seen_expect.run_last) begin
          $error("run_last: expected %0d, got %0d", seen_expect.run_last, run_last);
          error_count++;
        end
        if (message_done !== seen_expect.message_done) begin
          $error("message_done: expected %0d, got %0d",
                 seen_expect.message_done, message_done);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** playfair_digraph_cipher_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:       shadow_decrypt = value[0];
      REG_CELLS_LOW:  shadow_cells_low = value[59:0];
      REG_CELLS_HIGH: shadow_cells_high = value[59:0];
      REG_CELL_LAST:  shadow_cell_last = value[4:0];
      default: ;
    endcase
  endtask

  task automatic push_request(input letter_t ltr, input logic last);
    letter_requests.push_back('{letter: ltr, last: last});
    pushed_count++;
  endtask

  // Hold until every request is taken and every letter has come out
  task automatic wait_idle(input int unsigned settle);
    while (accepted_count != pushed_count || expected_letters.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Shuffled square of the 25 letters without J, optionally spoilt
  task automatic write_square(input logic spoil);
    letter_t codes[25];
    letter_t swap;
    logic [59:0] low_cells, high_cells;
    int n, j;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != LETTER_J) begin
        codes[n] = letter_t'(c);
        n++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = codes[i];
      codes[i] = codes[j];
      codes[j] = swap;
    end
    if (spoil) begin
      repeat ($urandom_range(1, 4))
        codes[$urandom_range(0, 24)] = letter_t'($urandom_range(0, 31));
    end
    for (int i = 0; i < 12; i++) begin
      low_cells[5*i +: 5] = codes[i];
      high_cells[5*i +: 5] = codes[12+i];
    end
    write_reg(REG_CELLS_LOW, {4'b0, low_cells});
    write_reg(REG_CELLS_HIGH, {4'b0, high_cells});
    write_reg(REG_CELL_LAST, {59'b0, codes[24]});
  endtask

  // Messages with doubled letters and out-of-range codes; the last one of a
  // batch may be cut short so that a held letter crosses into the next phase
  task automatic push_messages(input int unsigned count);
    int unsigned msg_len, pos;
    letter_t ltr;
    ltr = '0;
    while (count > 0) begin
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (pos = 1; pos <= msg_len && count > 0; pos++) begin
        if (pos == 1 || $urandom_range(0, 4) != 0) begin
          ltr = ($urandom_range(0, 9) == 0) ? letter_t'($urandom_range(26, 31))
                                             : letter_t'($urandom_range(0, 25));
        end
        count--;
        push_request(ltr, pos == msg_len || $urandom_range(0, 24) == 0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset square, encrypt: rows, columns, rectangles, fillers, folding, padding
    push_request(5'd11, 1'b0); push_request(5'd6, 1'b0);
    push_request(5'd11, 1'b0); push_request(5'd16, 1'b0);
    push_request(5'd6, 1'b0);  push_request(5'd2, 1'b0);
    push_request(5'd4, 1'b0);  push_request(5'd4, 1'b0);
    push_request(LETTER_X, 1'b0); push_request(LETTER_X, 1'b0);
    push_request(LETTER_X, 1'b1);
    push_request(LETTER_J, 1'b0); push_request(LETTER_I, 1'b0);
    push_request(5'd0, 1'b0);  push_request(LETTER_Z, 1'b1);
    push_request(5'd31, 1'b0); push_request(5'd26, 1'b0);
    push_request(5'd30, 1'b1);
    push_request(5'd1, 1'b0);  push_request(5'd2, 1'b1);
    push_request(5'd5, 1'b0);  push_request(5'd5, 1'b1);
    wait_idle(8);

    write_reg(REG_MODE, 64'd1);
    push_messages(40);
    wait_idle(8);

    for (int phase = 0; phase < 9; phase++) begin
      write_reg(REG_MODE, {63'b0, 1'($urandom_range(0, 1))});
      case (phase)
        0: begin
          write_reg(REG_CELLS_LOW, 64'd0);
          write_reg(REG_CELLS_HIGH, 64'd0);
          write_reg(REG_CELL_LAST, 64'd0);
        end
        1: begin
          write_reg(REG_CELLS_LOW, {4'b0, ALL_CELLS_SET});
          write_reg(REG_CELLS_HIGH, {4'b0, ALL_CELLS_SET});
          write_reg(REG_CELL_LAST, 64'd31);
        end
        2: begin
          write_reg(REG_CELLS_LOW, {4'b0, 28'($urandom), $urandom});
          write_reg(REG_CELLS_HIGH, {4'b0, 28'($urandom), $urandom});
          write_reg(REG_CELL_LAST, {59'b0, letter_t'($urandom)});
        end
        3: write_square(1'b1);
        default: write_square(1'b0);
      endcase
      if (phase == 4) begin
        // hold the sender until the block has drained completely
        push_messages(20);
        wait_idle(0);
        push_messages(20);
      end else begin
        push_messages(40);
      end
      wait_idle(8);
    end

    wait_idle(20);
    if (error_count == 0) begin
      $display("** playfair_digraph_cipher_top: PASSED **");
    end else begin
      $display("** playfair_digraph_cipher_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/pfc_pkg.sv
rtl/pfc_pair_cipher.sv
rtl/playfair_digraph_cipher_top.sv
tb/testbench.sv
